### rtl/pohl_pkg.sv
`timescale 1ns / 1ps

package pohl_pkg;

  localparam int unsigned MaxEntriesDef = 16;

  localparam int unsigned HandleW = 16;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned ThrW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 5;
  localparam int unsigned PosW    = 4;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CmdW    = 2;

  // One list entry as held in the entry memory
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [PrioW-1:0]   prio;
    logic [ThrW-1:0]    thr;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [CmdW-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_READ     = 2'd2,
    CMD_IGNORE   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_CTRL     = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RDWAIT,
    S_DONE
  } state_e;

endpackage

### rtl/pohl_ram.sv
`timescale 1ns / 1ps

module pohl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/priority_ordered_handler_list.sv
`timescale 1ns / 1ps

// Priority-ordered handler list.
// Input channel (in_valid_i / in_ready_o) carries one command per transfer:
// register a handler, remove a handler, or read the entry at a list index.
// Output channel (out_valid_o / out_ready_i) returns exactly one result per
// command: status, entry count after the command, insert position and, for a
// read, the entry fields. The control_mode register is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is
// idle, as the block itself does not enforce this. All entries live in one
// single-port-write RAM with a registered read; commands are handled one at
// a time by a read-modify-write sequencer. Register and remove commands scan
// the list; a register below the tail then shifts the later entries up one
// entry per cycle before writing its own. Null handles, unused commands and
// reads past the end go straight to the result. A new command can be taken
// in the cycle after the previous result is loaded into the output register.
// A finished result sits in an output register, so the next command can be
// taken while the receiver stalls; the sequencer holds in its final state
// only if the output register is still occupied.
// Reset empties the list and clears control_mode; RAM contents are not
// cleared, since only entries below the count are ever read.
module priority_ordered_handler_list
  import pohl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [HandleW-1:0] handle_i,
  input  logic [PrioW-1:0]   priority_req_i,
  input  logic [ThrW-1:0]    run_threshold_i,
  input  logic [IndexW-1:0]  read_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [CountW-1:0]  entry_count_o,
  output logic [PosW-1:0]    insert_position_o,
  output logic [HandleW-1:0] out_handle_o,
  output logic [PrioW-1:0]   out_priority_o,
  output logic [ThrW-1:0]    out_threshold_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned LW = $clog2(MAX_ENTRIES + 1);
  localparam logic [LW-1:0] LenMax = LW'(MAX_ENTRIES);

  // Sequencer and command registers
  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [HandleW-1:0]  hdl_q, hdl_d;
  logic [PrioW-1:0]    prio_q, prio_d;
  logic [ThrW-1:0]     thr_q, thr_d;
  logic                ctrl_mode_q;

  // Scan / shift pointers
  logic [LW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                pend_q, pend_d;
  logic [LW-1:0]       pend_idx_q, pend_idx_d;
  logic [LW-1:0]       wr_ptr_q, wr_ptr_d;
  logic                found_q, found_d;
  logic                pos_found_q, pos_found_d;
  logic [LW-1:0]       ins_pos_q, ins_pos_d;
  logic [LW-1:0]       len_q, len_d;

  // Working result
  status_e             res_status_q, res_status_d;
  logic [PosW-1:0]     res_pos_q, res_pos_d;
  entry_t              res_data_q, res_data_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [CountW-1:0]   out_count_q, out_count_d;
  logic [PosW-1:0]     out_pos_q, out_pos_d;
  entry_t              out_data_q, out_data_d;

  // RAM port
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata, rdata;
  logic [EntryW-1:0]   ram_rdata;

  logic                accept, hit, scan_end, out_free, idx_ok;
  logic [31:0]         len_ext, pos_ext, idx_ext;
  logic [LW-1:0]       ptr_dec;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rdata      = entry_t'(ram_rdata);
  assign hit        = pend_q && (rdata.handle == hdl_q);
  assign scan_end   = (rd_ptr_q == len_q) && !pend_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign len_ext    = 32'(len_q);
  assign pos_ext    = 32'(ins_pos_q);
  assign idx_ext    = 32'(read_index_i);
  assign idx_ok     = idx_ext < len_ext;
  assign ptr_dec    = rd_ptr_q - LW'(1);

  pohl_ram #(
    .Width (EntryW),
    .Depth (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(command_i))
            CMD_REGISTER: state_d = (handle_i == '0) ? S_DONE : S_SCAN;
            CMD_REMOVE:   state_d = S_SCAN;
            CMD_READ:     state_d = idx_ok ? S_RDWAIT : S_DONE;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (cmd_q == CMD_REGISTER && hit) begin
          state_d = S_DONE;
        end else if (scan_end) begin
          if (cmd_q == CMD_REGISTER &&
              !((ctrl_mode_q && len_q != '0) || len_q == LenMax)) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (rd_ptr_q == ins_pos_q && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_RDWAIT: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cmd_d        = cmd_q;
    hdl_d        = hdl_q;
    prio_d       = prio_q;
    thr_d        = thr_q;
    rd_ptr_d     = rd_ptr_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    wr_ptr_d     = wr_ptr_q;
    found_d      = found_q;
    pos_found_d  = pos_found_q;
    ins_pos_d    = ins_pos_q;
    len_d        = len_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_pos_d    = out_pos_q;
    out_data_d   = out_data_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d        = cmd_e'(command_i);
          hdl_d        = handle_i;
          prio_d       = priority_req_i;
          thr_d        = run_threshold_i;
          rd_ptr_d     = '0;
          pend_d       = 1'b0;
          wr_ptr_d     = '0;
          found_d      = 1'b0;
          pos_found_d  = 1'b0;
          ins_pos_d    = len_q;
          res_status_d = ST_OK;
          res_pos_d    = '0;
          res_data_d   = '0;
          case (cmd_e'(command_i))
            CMD_REGISTER: begin
              if (handle_i == '0) begin
                res_status_d = ST_NULL;
              end
            end
            CMD_READ: begin
              if (idx_ok) begin
                ram_re    = 1'b1;
                ram_raddr = idx_ext[AW-1:0];
              end else begin
                res_status_d = ST_NOTFOUND;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // issue the next read of the scan
        if (rd_ptr_q != len_q) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_ptr_q[AW-1:0];
          rd_ptr_d   = rd_ptr_q + LW'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q;
        end else begin
          pend_d = 1'b0;
        end
        // consume the entry read last cycle
        if (pend_q) begin
          if (cmd_q == CMD_REGISTER) begin
            if (hit) begin
              res_status_d = ST_DUP;
              pend_d       = 1'b0;
            end else if (!pos_found_q && rdata.prio < prio_q) begin
              pos_found_d = 1'b1;
              ins_pos_d   = pend_idx_q;
            end
          end else if (hit) begin
            found_d = 1'b1;
          end else begin
            // compact: move surviving entry down to the write pointer
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_q[AW-1:0];
            ram_wdata = rdata;
            wr_ptr_d  = wr_ptr_q + LW'(1);
          end
        end
        if (scan_end) begin
          pend_d = 1'b0;
          if (cmd_q == CMD_REGISTER) begin
            if (ctrl_mode_q && len_q != '0) begin
              res_status_d = ST_CTRL;
            end else if (len_q == LenMax) begin
              res_status_d = ST_FULL;
            end else begin
              rd_ptr_d = len_q;
            end
          end else if (found_q) begin
            len_d = wr_ptr_q;
          end else begin
            res_status_d = ST_NOTFOUND;
          end
        end
      end
      S_SHIFT: begin
        // rd_ptr walks from the list end down to the insert slot
        pend_d = 1'b0;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q[AW-1:0];
          ram_wdata = rdata;
        end
        if (rd_ptr_q != ins_pos_q) begin
          ram_re     = 1'b1;
          ram_raddr  = ptr_dec[AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q;
          rd_ptr_d   = ptr_dec;
        end else if (!pend_q) begin
          ram_we           = 1'b1;
          ram_waddr        = ins_pos_q[AW-1:0];
          ram_wdata.handle = hdl_q;
          ram_wdata.prio   = prio_q;
          ram_wdata.thr    = thr_q;
          len_d            = len_q + LW'(1);
          res_pos_d        = pos_ext[PosW-1:0];
        end
      end
      S_RDWAIT: begin
        res_data_d = rdata;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_count_d  = len_ext[CountW-1:0];
          out_pos_d    = res_pos_q;
          out_data_d   = res_data_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ctrl_mode_q <= 1'b0;
      len_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ctrl_mode_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    hdl_q        <= hdl_d;
    prio_q       <= prio_d;
    thr_q        <= thr_d;
    rd_ptr_q     <= rd_ptr_d;
    pend_idx_q   <= pend_idx_d;
    wr_ptr_q     <= wr_ptr_d;
    found_q      <= found_d;
    pos_found_q  <= pos_found_d;
    ins_pos_q    <= ins_pos_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_pos_q    <= out_pos_d;
    out_data_q   <= out_data_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign entry_count_o     = out_count_q;
  assign insert_position_o = out_pos_q;
  assign out_handle_o      = out_data_q.handle;
  assign out_priority_o    = out_data_q.prio;
  assign out_threshold_o   = out_data_q.thr;

`ifndef SYNTHESIS
  // List never grows past capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LenMax)
    else $error("entry count exceeds capacity");

  // RAM is only written while a command is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && (state_q == S_IDLE || state_q == S_DONE)))
    else $error("entry RAM written outside a command");

  // One command at a time: a transfer closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> !in_ready_o)
    else $error("input ready while a command is in progress");

  // A result is loaded only when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");
`endif

endmodule

### sim/priority_ordered_handler_list_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the priority-ordered handler list.
module priority_ordered_handler_list_tb;
  import pohl_pkg::*;

  localparam int unsigned MAX_ENTRIES = MaxEntriesDef;
  localparam int          CycleLimit  = 1_000_000;
  localparam int          PoolSize    = 24;
  localparam int          PrintLimit  = 50;

  // One command as driven on the input channel
  typedef struct {
    cmd_e               cmd;
    logic [HandleW-1:0] handle;
    logic [PrioW-1:0]   prio;
    logic [ThrW-1:0]    thr;
    logic [IndexW-1:0]  idx;
  } list_cmd_t;

  // One result as expected on the output channel
  typedef struct {
    status_e            status;
    logic [CountW-1:0]  count;
    logic [PosW-1:0]    pos;
    logic [HandleW-1:0] handle;
    logic [PrioW-1:0]   prio;
    logic [ThrW-1:0]    thr;
  } list_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  list_cmd_t cur_cmd    = '{CMD_REGISTER, '0, '0, '0, '0};

  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  entry_count_o;
  logic [PosW-1:0]    insert_position_o;
  logic [HandleW-1:0] out_handle_o;
  logic [PrioW-1:0]   out_priority_o;
  logic [ThrW-1:0]    out_threshold_o;

  // Shadow copy of the list, updated at each accepted command
  logic [HandleW-1:0] shadow_handle [MAX_ENTRIES];
  logic [PrioW-1:0]   shadow_prio   [MAX_ENTRIES];
  logic [ThrW-1:0]    shadow_thr    [MAX_ENTRIES];
  int                 shadow_len  = 0;
  bit                 shadow_ctrl = 1'b0;

  list_cmd_t    pending_cmds[$];
  list_result_t predicted_results[$];
  logic [HandleW-1:0] handle_pool [PoolSize];

  int  queued_cmds   = 0;
  int  accepted_cmds = 0;
  int  results_seen  = 0;
  int  fail_count    = 0;
  int  cycle_count   = 0;
  bit  in_xfer       = 1'b0;

  // Sender burst state
  int burst_left = 1;
  int gap_left   = 0;

  // Receiver stall state
  int rx_mode      = 0;
  int mode_left    = 0;
  int hold_left    = 0;
  int next_hold_at = 150;

  priority_ordered_handler_list #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (cur_cmd.cmd),
    .handle_i         (cur_cmd.handle),
    .priority_req_i   (cur_cmd.prio),
    .run_threshold_i  (cur_cmd.thr),
    .read_index_i     (cur_cmd.idx),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .entry_count_o    (entry_count_o),
    .insert_position_o(insert_position_o),
    .out_handle_o     (out_handle_o),
    .out_priority_o   (out_priority_o),
    .out_threshold_o  (out_threshold_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one command to the shadow list and return the result it must give.
  function automatic list_result_t apply_list_command(list_cmd_t c);
    list_result_t r;
    int           ins_at;
    int           wr;
    bit           dup;
    bit           hit;
    r = '{ST_OK, '0, '0, '0, '0, '0};
    case (c.cmd)
      CMD_REGISTER: begin
        // Find the first strictly lower priority; equal priorities keep order
        ins_at = shadow_len;
        dup    = 1'b0;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_handle[i] == c.handle) dup = 1'b1;
          if (ins_at == shadow_len && shadow_prio[i] < c.prio) ins_at = i;
        end
        if (c.handle == '0) begin
          r.status = ST_NULL;
        end else if (dup) begin
          r.status = ST_DUP;
        end else if (shadow_ctrl && shadow_len > 0) begin
          r.status = ST_CTRL;
        end else if (shadow_len >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > ins_at; i--) begin
            shadow_handle[i] = shadow_handle[i-1];
            shadow_prio[i]   = shadow_prio[i-1];
            shadow_thr[i]    = shadow_thr[i-1];
          end
          shadow_handle[ins_at] = c.handle;
          shadow_prio[ins_at]   = c.prio;
          shadow_thr[ins_at]    = c.thr;
          shadow_len++;
          r.pos = PosW'(ins_at);
        end
      end
      CMD_REMOVE: begin
        // Drop every match and compact the survivors toward the head
        wr  = 0;
        hit = 1'b0;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_handle[i] == c.handle) begin
            hit = 1'b1;
          end else begin
            shadow_handle[wr] = shadow_handle[i];
            shadow_prio[wr]   = shadow_prio[i];
            shadow_thr[wr]    = shadow_thr[i];
            wr++;
          end
        end
        if (hit) shadow_len = wr;
        else     r.status = ST_NOTFOUND;
      end
      CMD_READ: begin
        if (int'(c.idx) < shadow_len) begin
          r.handle = shadow_handle[c.idx];
          r.prio   = shadow_prio[c.idx];
          r.thr    = shadow_thr[c.idx];
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    r.count = CountW'(shadow_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < PrintLimit) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic queue_cmd(input cmd_e c, input logic [HandleW-1:0] h,
                           input logic [PrioW-1:0] p, input logic [ThrW-1:0] t,
                           input logic [IndexW-1:0] idx);
    pending_cmds.push_back('{c, h, p, t, idx});
    queued_cmds++;
  endtask

  // Hold until every queued command has been accepted and answered.
  task automatic wait_list_idle();
    while (accepted_cmds != queued_cmds || results_seen != accepted_cmds)
      @(negedge clk_i);
  endtask

  // Write control_mode; only called while the list is idle.
  task automatic set_control_mode(input bit v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_ctrl = v;
  endtask

  // Mostly pool handles so that duplicates and removes hit the list.
  function automatic logic [HandleW-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return handle_pool[$urandom_range(0, PoolSize - 1)];
    if (r < 90) return '0;
    return HandleW'($urandom_range(1, 65535));
  endfunction

  // Mostly a few coarse levels so that ties are common.
  function automatic logic [PrioW-1:0] pick_prio();
    if ($urandom_range(0, 9) < 7) return PrioW'($urandom_range(0, 3) * 85);
    return PrioW'($urandom_range(0, 255));
  endfunction

  // Queue runs of related commands: fills, read sweeps, drains, mixes, noise.
  // Every item starts from fully random fields so unused inputs toggle too.
  task automatic queue_random_commands(input int n);
    int        added;
    int        run_len;
    int        kind;
    list_cmd_t c;
    added = 0;
    while (added < n) begin
      kind    = $urandom_range(0, 9);
      run_len = $urandom_range(4, 20);
      for (int j = 0; j < run_len; j++) begin
        c.cmd    = cmd_e'($urandom_range(0, 3));
        c.handle = HandleW'($urandom_range(0, 65535));
        c.prio   = PrioW'($urandom_range(0, 255));
        c.thr    = ThrW'($urandom);
        c.idx    = IndexW'($urandom_range(0, 15));
        case (kind)
          0, 1, 2: begin
            c.cmd    = CMD_REGISTER;
            c.handle = pick_handle();
            c.prio   = pick_prio();
          end
          3: begin
            c.cmd = CMD_READ;
            c.idx = IndexW'(j);
          end
          4, 5: begin
            c.cmd    = CMD_REMOVE;
            c.handle = pick_handle();
          end
          6, 7, 8: begin
            c.cmd    = cmd_e'($urandom_range(0, 2));
            c.handle = pick_handle();
            c.prio   = pick_prio();
          end
          default: ;
        endcase
        queue_cmd(c.cmd, c.handle, c.prio, c.thr, c.idx);
        added++;
      end
    end
  endtask

  // Driver: advance to the next pending command once the current one is
  // transferred, in bursts separated by random gaps.
  always @(negedge clk_i) begin : drive_cmds
    logic      nxt_valid;
    list_cmd_t nxt_cmd;
    nxt_valid = in_valid_i;
    nxt_cmd   = cur_cmd;
    if (rst_ni && (!in_valid_i || in_xfer)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        nxt_cmd   = pending_cmds.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end
    in_valid_i <= nxt_valid;
    cur_cmd    <= nxt_cmd;
  end

  // Receiver: switch between stall patterns, and now and then hold off for
  // a long stretch so the block backs up and drops in_ready_o.
  always @(negedge clk_i) begin : drive_ready
    logic nxt_ready;
    if (hold_left == 0 && results_seen >= next_hold_at) begin
      hold_left    = 400;
      next_hold_at = next_hold_at + 700;
    end
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(30, 150);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else begin
      case (rx_mode)
        0:       nxt_ready = 1'b1;
        1:       nxt_ready = ($urandom_range(0, 3) != 0);
        2:       nxt_ready = ($urandom_range(0, 3) == 0);
        default: nxt_ready = ~out_ready_i;
      endcase
    end
    out_ready_i <= nxt_ready;
  end

  // Monitor: check each result transfer against the oldest prediction, then
  // predict for a command transfer in the same cycle.
  always @(posedge clk_i) begin : check_results
    list_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no command outstanding");
        end else begin
          exp_r = predicted_results.pop_front();
          if (status_o !== exp_r.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      results_seen, status_o, exp_r.status));
          if (entry_count_o !== exp_r.count)
            report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                      results_seen, entry_count_o, exp_r.count));
          if (insert_position_o !== exp_r.pos)
            report_mismatch($sformatf("result %0d insert_position %0d, want %0d",
                                      results_seen, insert_position_o, exp_r.pos));
          if (out_handle_o !== exp_r.handle)
            report_mismatch($sformatf("result %0d out_handle %h, want %h",
                                      results_seen, out_handle_o, exp_r.handle));
          if (out_priority_o !== exp_r.prio)
            report_mismatch($sformatf("result %0d out_priority %h, want %h",
                                      results_seen, out_priority_o, exp_r.prio));
          if (out_threshold_o !== exp_r.thr)
            report_mismatch($sformatf("result %0d out_threshold %h, want %h",
                                      results_seen, out_threshold_o, exp_r.thr));
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted_results.push_back(apply_list_command(cur_cmd));
        accepted_cmds++;
      end
    end
    in_xfer <= rst_ni && in_valid_i && in_ready_o;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : run_phases
    for (int i = 0; i < PoolSize; i++)
      handle_pool[i] = HandleW'($urandom_range(1, 65535));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Control hook on an empty list: one handler only, checks still ordered
    set_control_mode(1'b1);
    queue_cmd(CMD_REGISTER, 16'h00A5, 8'd10, 32'h0000_0001, '0);
    queue_cmd(CMD_REGISTER, 16'h5A00, 8'd255, 32'h1234_5678, '0);
    queue_cmd(CMD_REGISTER, 16'h00A5, 8'd255, 32'h0, '0);
    queue_cmd(CMD_REGISTER, 16'h0000, 8'd1, 32'h0, '0);
    queue_cmd(CMD_READ, 16'h0, 8'd0, 32'h0, 4'd0);
    queue_cmd(CMD_REMOVE, 16'h00A5, 8'd0, 32'h0, '0);
    queue_cmd(CMD_REGISTER, 16'h5A00, 8'd255, 32'hFFFF_FFFF, '0);
    queue_cmd(CMD_REMOVE, 16'h5A00, 8'd0, 32'h0, '0);
    wait_list_idle();

    // Normal mode: null handle, ignored opcode, empty-list misses, then fill
    // to capacity with ties at both priority extremes
    set_control_mode(1'b0);
    queue_cmd(CMD_REGISTER, 16'h0000, 8'd200, 32'hDEAD_BEEF, '0);
    queue_cmd(CMD_IGNORE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 4'hF);
    queue_cmd(CMD_READ, 16'h0, 8'd0, 32'h0, 4'd0);
    queue_cmd(CMD_REMOVE, 16'h1234, 8'd0, 32'h0, '0);
    for (int i = 0; i < MAX_ENTRIES; i++)
      queue_cmd(CMD_REGISTER,
                (i == 0) ? 16'hFFFF : HandleW'(i * 16'h0911),
                (i % 3 == 0) ? 8'd0 : ((i % 3 == 1) ? 8'd255 : 8'd128),
                (i == 0) ? 32'h0 : ((i == 1) ? 32'hFFFF_FFFF : ThrW'($urandom)),
                '0);
    // Full list; duplicate is reported ahead of full
    queue_cmd(CMD_REGISTER, 16'h7777, 8'd50, 32'h0, '0);
    queue_cmd(CMD_REGISTER, 16'hFFFF, 8'd50, 32'h0, '0);
    queue_cmd(CMD_READ, 16'h0, 8'd0, 32'h0, 4'd15);
    queue_cmd(CMD_READ, 16'h0, 8'd0, 32'h0, 4'd0);
    queue_cmd(CMD_REMOVE, 16'h0000, 8'd0, 32'h0, '0);
    queue_cmd(CMD_REMOVE, 16'h0911, 8'd0, 32'h0, '0);
    queue_cmd(CMD_READ, 16'h0, 8'd0, 32'h0, 4'd15);
    wait_list_idle();

    // Random traffic across both settings of control_mode
    queue_random_commands(1100);
    wait_list_idle();
    set_control_mode(1'b1);
    queue_random_commands(200);
    wait_list_idle();
    set_control_mode(1'b0);
    queue_random_commands(200);
    wait_list_idle();

    // Let any stray result show up before the verdict
    repeat (2 * MAX_ENTRIES + 10) @(posedge clk_i);
    if (predicted_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
